// ===== hdl/ppou_pkg.sv =====
// Shared types, codes and arithmetic helpers of the pixel point-operation unit.
// Depends on nothing; the config, stage and top-level modules import it.
package ppou_pkg;

  localparam int unsigned NCH = 3;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_EFFECT      = 3'd0;
  localparam logic [2:0] REG_BRIGHT_OFS  = 3'd1;
  localparam logic [2:0] REG_CONTR_GAIN  = 3'd2;
  localparam logic [2:0] REG_GRAY_W      = 3'd3;
  localparam logic [2:0] REG_THR_MODE    = 3'd4;
  localparam logic [2:0] REG_THR_LEVEL   = 3'd5;
  localparam logic [2:0] REG_THR_MAX     = 3'd6;
  localparam logic [2:0] REG_THR_PER_CH  = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // Effect codes
  localparam logic [2:0] FX_BRIGHT   = 3'd0;
  localparam logic [2:0] FX_CONTRAST = 3'd1;
  localparam logic [2:0] FX_NEGATIVE = 3'd2;
  localparam logic [2:0] FX_GRAY     = 3'd3;
  localparam logic [2:0] FX_THRESH   = 3'd4;

  // Threshold mode codes
  localparam logic [2:0] TM_BINARY     = 3'd0;
  localparam logic [2:0] TM_BINARY_INV = 3'd1;
  localparam logic [2:0] TM_TOZERO     = 3'd2;
  localparam logic [2:0] TM_TOZERO_INV = 3'd3;
  localparam logic [2:0] TM_TRUNC      = 3'd4;

  // BT.601 luma weights, Q.14
  localparam logic [13:0] LUMA_W0 = 14'd1868;
  localparam logic [13:0] LUMA_W1 = 14'd9617;
  localparam logic [13:0] LUMA_W2 = 14'd4899;
  localparam logic [21:0] LUMA_RND = 22'd8192;

  localparam logic signed [25:0] CONTR_BIAS = 26'sd32768;

  typedef logic [7:0] pix_t;

  typedef struct packed {
    logic [2:0]         effect;
    logic signed [8:0]  bright_ofs;
    logic signed [15:0] contr_gain;
    logic [47:0]        gray_w;
    logic [2:0]         thr_mode;
    logic [7:0]         thr_level;
    logic [7:0]         thr_max;
    logic               thr_per_ch;
  } cfg_t;

  // After the multiply stage
  typedef struct packed {
    pix_t [NCH-1:0]              chan;
    logic [NCH-1:0][24:0]        prod;   // signed gain or weight products
    logic [NCH-1:0][21:0]        luma;   // luma partial products
    logic [NCH-1:0][9:0]         bsum;   // signed channel plus offset
  } mul_t;

  // After the accumulate / round stage
  typedef struct packed {
    pix_t [NCH-1:0]              chan;
    logic [NCH-1:0][17:0]        cq;     // signed rounded contrast values
    logic signed [25:0]          gsum;
    pix_t                        luma;
    logic [NCH-1:0][9:0]         bsum;
  } acc_t;

  typedef struct packed {
    pix_t [NCH-1:0] pix;
  } res_t;

  function automatic pix_t sat_bright(input logic signed [9:0] v);
    pix_t r;
    if (v < 0) r = 8'd0;
    else if (v > 10'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  function automatic pix_t sat_contr(input logic signed [17:0] v);
    pix_t r;
    if (v < 0) r = 8'd0;
    else if (v > 18'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  // Truncate a Q.12 sum toward zero and clamp; negative sums land on zero
  function automatic pix_t sat_gray(input logic signed [25:0] s);
    pix_t r;
    if (s < 0) r = 8'd0;
    else if (s[24:20] != 5'd0) r = 8'd255;
    else r = s[19:12];
    return r;
  endfunction

  function automatic pix_t thresh(input pix_t v, input logic [2:0] mode,
                                  input pix_t level, input pix_t maxv);
    logic above;
    pix_t r;
    above = v > level;
    case (mode)
      TM_BINARY:     r = above ? maxv : 8'd0;
      TM_BINARY_INV: r = above ? 8'd0 : maxv;
      TM_TOZERO:     r = above ? v : 8'd0;
      TM_TOZERO_INV: r = above ? 8'd0 : v;
      TM_TRUNC:      r = above ? level : v;
      default:       r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ppou_in_if.sv =====
// Input pixel channel: valid/ready handshake with three 8-bit channels.
// Depends on nothing.
interface ppou_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;

  modport source (output valid, output chan0, output chan1, output chan2, input ready);
  modport sink   (input valid, input chan0, input chan1, input chan2, output ready);
endinterface

// ===== hdl/ppou_out_if.sv =====
// Result pixel channel: valid/ready handshake with three 8-bit outputs.
// Depends on nothing.
interface ppou_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out0;
  logic [7:0] out1;
  logic [7:0] out2;

  modport source (output valid, output out0, output out1, output out2, input ready);
  modport sink   (input valid, input out0, input out1, input out2, output ready);
endinterface

// ===== hdl/ppou_cfg_regs.sv =====
// Configuration register file, written through the plain write port.
// Depends on ppou_pkg.
module ppou_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ppou_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ppou_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output ppou_pkg::cfg_t                      cfg
);
  import ppou_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.effect     <= FX_BRIGHT;
      cfg_r.bright_ofs <= 9'sd0;
      cfg_r.contr_gain <= 16'sd256;
      cfg_r.gray_w     <= 48'd0;
      cfg_r.thr_mode   <= TM_BINARY;
      cfg_r.thr_level  <= 8'd128;
      cfg_r.thr_max    <= 8'd255;
      cfg_r.thr_per_ch <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_EFFECT:     cfg_r.effect     <= cfg_wdata[2:0];
        REG_BRIGHT_OFS: cfg_r.bright_ofs <= cfg_wdata[8:0];
        REG_CONTR_GAIN: cfg_r.contr_gain <= cfg_wdata[15:0];
        REG_GRAY_W:     cfg_r.gray_w     <= cfg_wdata[47:0];
        REG_THR_MODE:   cfg_r.thr_mode   <= cfg_wdata[2:0];
        REG_THR_LEVEL:  cfg_r.thr_level  <= cfg_wdata[7:0];
        REG_THR_MAX:    cfg_r.thr_max    <= cfg_wdata[7:0];
        REG_THR_PER_CH: cfg_r.thr_per_ch <= cfg_wdata[0];
        default:        cfg_r.effect     <= cfg_r.effect;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

// ===== hdl/ppou_mul_stage.sv =====
// Stage 1: per-channel gain/weight multiply, luma products and brightness add.
// Depends on ppou_pkg.
module ppou_mul_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  ppou_pkg::cfg_t    cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  ppou_pkg::pix_t [ppou_pkg::NCH-1:0] up_chan,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ppou_pkg::mul_t    dn_data
);
  import ppou_pkg::*;

  logic valid_r;
  mul_t data_r;
  mul_t data_nxt;
  logic signed [15:0] mul_a [NCH];
  logic signed [8:0]  mul_b [NCH];
  logic signed [24:0] mul_p [NCH];
  logic [13:0]        luma_w [NCH];

  assign luma_w[0] = LUMA_W0;
  assign luma_w[1] = LUMA_W1;
  assign luma_w[2] = LUMA_W2;

  // One shared multiplier per channel: contrast gain or gray weight
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      if (cfg.effect == FX_CONTRAST) begin
        mul_a[i] = cfg.contr_gain;
        mul_b[i] = $signed({1'b0, up_chan[i]}) - 9'sd128;
      end else begin
        mul_a[i] = cfg.gray_w[16*i +: 16];
        mul_b[i] = $signed({1'b0, up_chan[i]});
      end
      mul_p[i] = mul_a[i] * mul_b[i];
      data_nxt.chan[i] = up_chan[i];
      data_nxt.prod[i] = mul_p[i];
      data_nxt.luma[i] = luma_w[i] * up_chan[i];
      data_nxt.bsum[i] = $signed({2'b00, up_chan[i]}) +
                         $signed({cfg.bright_ofs[8], cfg.bright_ofs});
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;
endmodule

// ===== hdl/ppou_acc_stage.sv =====
// Stage 2: contrast rounding (ties to even), gray and luma sums.
// Depends on ppou_pkg.
module ppou_acc_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  ppou_pkg::mul_t    up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ppou_pkg::acc_t    dn_data
);
  import ppou_pkg::*;

  logic valid_r;
  acc_t data_r;
  acc_t data_nxt;
  logic signed [25:0] p [NCH];
  logic signed [17:0] q [NCH];
  logic [7:0]         rem [NCH];
  logic               inc [NCH];
  logic [21:0]        luma_sum;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      p[i]   = $signed({up_data.prod[i][24], up_data.prod[i]}) + CONTR_BIAS;
      q[i]   = p[i][25:8];
      rem[i] = p[i][7:0];
      inc[i] = (rem[i] > 8'd128) || ((rem[i] == 8'd128) && q[i][0]);
      data_nxt.cq[i]   = q[i] + $signed({17'd0, inc[i]});
      data_nxt.chan[i] = up_data.chan[i];
      data_nxt.bsum[i] = up_data.bsum[i];
    end
    data_nxt.gsum = $signed({up_data.prod[0][24], up_data.prod[0]}) +
                    $signed({up_data.prod[1][24], up_data.prod[1]}) +
                    $signed({up_data.prod[2][24], up_data.prod[2]});
    luma_sum = up_data.luma[0] + up_data.luma[1] + up_data.luma[2] + LUMA_RND;
    data_nxt.luma = luma_sum[21:14];
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;
endmodule

// ===== hdl/ppou_out_stage.sv =====
// Stage 3: saturation, thresholding and effect select into the output register.
// Depends on ppou_pkg.
module ppou_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  ppou_pkg::cfg_t    cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  ppou_pkg::acc_t    up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ppou_pkg::res_t    dn_data
);
  import ppou_pkg::*;

  logic valid_r;
  res_t data_r;
  res_t data_nxt;
  pix_t gray_v;
  pix_t luma_thr;

  always_comb begin
    gray_v   = sat_gray(up_data.gsum);
    luma_thr = thresh(up_data.luma, cfg.thr_mode, cfg.thr_level, cfg.thr_max);
    for (int i = 0; i < NCH; i++) begin
      case (cfg.effect)
        FX_BRIGHT:   data_nxt.pix[i] = sat_bright(up_data.bsum[i]);
        FX_CONTRAST: data_nxt.pix[i] = sat_contr(up_data.cq[i]);
        FX_NEGATIVE: data_nxt.pix[i] = ~up_data.chan[i];
        FX_GRAY:     data_nxt.pix[i] = gray_v;
        FX_THRESH:   data_nxt.pix[i] = cfg.thr_per_ch ?
                       thresh(up_data.chan[i], cfg.thr_mode, cfg.thr_level, cfg.thr_max) :
                       luma_thr;
        default:     data_nxt.pix[i] = up_data.chan[i];
      endcase
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;
endmodule

// ===== hdl/pixel_point_operation_unit.sv =====
// Top level of the pixel point-operation unit: config registers and three stages.
// Depends on ppou_pkg, ppou_in_if, ppou_out_if and the ppou stage modules.
//
//   port      dir   handshake      payload
//   in_pix    in    valid/ready    chan0, chan1, chan2 (8 bit each)
//   out_pix   out   valid/ready    out0, out1, out2 (8 bit each)
//   cfg_*     in    write enable   cfg_idx (3 bit), cfg_wdata (48 bit)
//
// One item per cycle sustained unless out_pix stalls; items pass the stages in turn
// (multiply, accumulate/round, saturate/select), the last being the output register.
// Synchronous active-low reset empties the pipe and loads register defaults.
// A stall on out_pix holds each full stage; a stage still takes an item while
// the one after it drains, so no bubble is added.
module pixel_point_operation_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  ppou_in_if.sink                          in_pix,
  ppou_out_if.source                       out_pix,
  input  logic                             cfg_we,
  input  logic [ppou_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ppou_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ppou_pkg::*;

  cfg_t           cfg;
  pix_t [NCH-1:0] in_chan;
  logic           s1_valid;
  logic           s1_ready;
  mul_t           s1_data;
  logic           s2_valid;
  logic           s2_ready;
  acc_t           s2_data;
  res_t           res;

  assign in_chan[0] = in_pix.chan0;
  assign in_chan[1] = in_pix.chan1;
  assign in_chan[2] = in_pix.chan2;

  ppou_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ppou_mul_stage u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_pix.valid),
    .up_ready (in_pix.ready),
    .up_chan  (in_chan),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  ppou_acc_stage u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  ppou_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_pix.valid),
    .dn_ready (out_pix.ready),
    .dn_data  (res)
  );

  assign out_pix.out0 = res.pix[0];
  assign out_pix.out1 = res.pix[1];
  assign out_pix.out2 = res.pix[2];
endmodule
